/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the chain link reorder buffer.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hw/rtl/clrb_pkg.sv */
// ----------------------------------------------------------------------------
// clrb_pkg
// Types and codes of the chain link reorder buffer.
// ----------------------------------------------------------------------------
package clrb_pkg;

  typedef struct packed {
    logic signed [7:0] up;
    logic signed [7:0] id;
    logic signed [7:0] down;
  } link_t;

  typedef logic [2:0] kind_t;

  localparam kind_t KIND_APPEND   = 3'd0;
  localparam kind_t KIND_LEAF_ADD = 3'd1;
  localparam kind_t KIND_LEAF_DEL = 3'd2;
  localparam kind_t KIND_BUFFERED = 3'd3;
  localparam kind_t KIND_REJECTED = 3'd4;
  localparam kind_t KIND_DROPPED  = 3'd5;

  localparam logic signed [7:0] NO_LINK = -8'sd1;

  localparam logic CMD_REPORT = 1'b0;
  localparam logic CMD_START  = 1'b1;

  localparam logic REG_ROOT_NODE = 1'b0;
  localparam logic REG_ROOT_NEXT = 1'b1;

endpackage

/* hw/rtl/chain_link_reorder_buffer_core.sv */
// ----------------------------------------------------------------------------
// chain_link_reorder_buffer_core
// Assembles out-of-order node reports into an ordered daisy chain, keeping
// unmatched reports in a pending memory that is scanned after each append.
// ----------------------------------------------------------------------------
// Results pass a one-deep hold register, so a result leaves in the cycle after the next
// one is produced, and the last result of an item in the first cycle with busy low.
// Busy stays high while a start or a report is handled, including any scan of the pending memory,
// its compaction and the moves of entries to the chain. The receiver cannot stall the results.
// Reset clears the state, the chain and pending counts, the leaf flag and the valid flags;
// memory contents need no clearing.
`include "assert_macros.svh"

module chain_link_reorder_buffer_core #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              start,
  output logic              busy,
  input  logic              cmd_i,
  input  logic signed [7:0] upstream_i,
  input  logic signed [7:0] node_i,
  input  logic signed [7:0] downstream_i,
  output logic              result_valid_o,
  output clrb_pkg::kind_t   kind_o,
  output logic signed [7:0] entry_up_o,
  output logic signed [7:0] entry_id_o,
  output logic signed [7:0] entry_down_o,
  output logic [4:0]        chain_len_o,
  output logic              last_o
);
  import clrb_pkg::*;

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);
  localparam logic [CW-1:0] ONE     = CW'(1);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_DECIDE  = 4'd1;
  localparam logic [3:0] ST_DRAIN   = 4'd2;
  localparam logic [3:0] ST_SCAN_RD = 4'd3;
  localparam logic [3:0] ST_SCAN_CK = 4'd4;
  localparam logic [3:0] ST_MOVE_RD = 4'd5;
  localparam logic [3:0] ST_MOVE_WR = 4'd6;
  localparam logic [3:0] ST_LEAF    = 4'd7;
  localparam logic [3:0] ST_FLUSH   = 4'd8;

  logic [3:0]        state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [CW-1:0]     pcnt_q, pcnt_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic              leaf_q, leaf_d;
  logic signed [7:0] tail_id_q, tail_id_d;
  logic signed [7:0] tail_down_q, tail_down_d;
  link_t             rep_q, rep_d;
  logic [6:0]        root_node_q, root_next_q;

  link_t             pend_mem [MAX_ENTRIES];
  link_t             rd_q;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [AW-1:0]     mem_raddr;
  link_t             mem_wdata;

  logic              prod;
  kind_t             prod_kind;
  link_t             prod_link;
  logic [CW-1:0]     prod_len;
  logic              flush;

  logic              held_v_q;
  kind_t             held_kind_q;
  link_t             held_link_q;
  logic [CW-1:0]     held_len_q;

  logic              res_v_q;
  kind_t             res_kind_q;
  link_t             res_link_q;
  logic [CW-1:0]     res_len_q;
  logic              res_last_q;

  logic              accept;
  logic              cfg_wr;
  logic              bad_field;
  link_t             in_link;
  logic [CW-1:0]     idx_inc;

  assign pready    = 1'b1;
  assign busy      = (state_q != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign in_link   = '{up: upstream_i, id: node_i, down: downstream_i};
  assign bad_field = upstream_i[7] | node_i[7] | downstream_i[7];
  assign idx_inc   = idx_q + ONE;
  assign flush     = (state_q == ST_FLUSH);

  always_comb begin
    prdata = 32'd0;
    if (psel) begin
      case (paddr[2])
        REG_ROOT_NODE: prdata = {25'd0, root_node_q};
        REG_ROOT_NEXT: prdata = {25'd0, root_next_q};
        default:       prdata = 32'd0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_node_q <= 7'd0;
      root_next_q <= 7'd1;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_ROOT_NODE: root_node_q <= pwdata[6:0];
        REG_ROOT_NEXT: root_next_q <= pwdata[6:0];
        default:       root_node_q <= root_node_q;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pcnt_d      = pcnt_q;
    idx_d       = idx_q;
    leaf_d      = leaf_q;
    tail_id_d   = tail_id_q;
    tail_down_d = tail_down_q;
    rep_d       = rep_q;
    prod        = 1'b0;
    prod_kind   = KIND_APPEND;
    prod_link   = rd_q;
    prod_len    = cnt_q;
    mem_we      = 1'b0;
    mem_waddr   = idx_q[AW-1:0];
    mem_wdata   = rd_q;
    mem_raddr   = idx_q[AW-1:0];

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          rep_d = in_link;
          if (cmd_i == CMD_START) begin
            cnt_d       = ONE;
            leaf_d      = 1'b0;
            tail_id_d   = {1'b0, root_node_q};
            tail_down_d = {1'b0, root_next_q};
            prod        = 1'b1;
            prod_kind   = KIND_APPEND;
            prod_link   = '{up: NO_LINK, id: {1'b0, root_node_q},
                            down: {1'b0, root_next_q}};
            prod_len    = ONE;
            state_d     = ST_DRAIN;
          end else if (bad_field) begin
            prod      = 1'b1;
            prod_kind = KIND_REJECTED;
            prod_link = in_link;
            state_d   = ST_FLUSH;
          end else if (leaf_q) begin
            cnt_d     = cnt_q - ONE;
            leaf_d    = 1'b0;
            prod      = 1'b1;
            prod_kind = KIND_LEAF_DEL;
            prod_link = '{up: tail_id_q, id: tail_down_q, down: NO_LINK};
            prod_len  = cnt_q - ONE;
            state_d   = ST_DECIDE;
          end else begin
            state_d = ST_DECIDE;
          end
        end
      end
      ST_DECIDE: begin
        prod      = 1'b1;
        prod_link = rep_q;
        state_d   = ST_FLUSH;
        if (cnt_q != '0 && rep_q.id == tail_down_q) begin
          if (cnt_q < MAX_CNT) begin
            cnt_d       = cnt_q + ONE;
            tail_id_d   = rep_q.id;
            tail_down_d = rep_q.down;
            prod_kind   = KIND_APPEND;
            prod_len    = cnt_q + ONE;
            state_d     = ST_DRAIN;
          end else begin
            prod_kind = KIND_DROPPED;
          end
        end else if (pcnt_q < MAX_CNT) begin
          mem_we    = 1'b1;
          mem_waddr = pcnt_q[AW-1:0];
          mem_wdata = rep_q;
          pcnt_d    = pcnt_q + ONE;
          prod_kind = KIND_BUFFERED;
        end else begin
          prod_kind = KIND_DROPPED;
        end
      end
      ST_DRAIN: begin
        idx_d = '0;
        if (cnt_q < MAX_CNT && pcnt_q != '0) begin
          state_d = ST_SCAN_RD;
        end else begin
          state_d = ST_LEAF;
        end
      end
      ST_SCAN_RD: begin
        mem_raddr = idx_q[AW-1:0];
        state_d   = ST_SCAN_CK;
      end
      ST_SCAN_CK: begin
        if (rd_q.id == tail_down_q) begin
          cnt_d       = cnt_q + ONE;
          pcnt_d      = pcnt_q - ONE;
          tail_id_d   = rd_q.id;
          tail_down_d = rd_q.down;
          prod        = 1'b1;
          prod_kind   = KIND_APPEND;
          prod_link   = rd_q;
          prod_len    = cnt_q + ONE;
          state_d     = (idx_inc < pcnt_q) ? ST_MOVE_RD : ST_DRAIN;
        end else if (idx_inc == pcnt_q) begin
          state_d = ST_LEAF;
        end else begin
          idx_d   = idx_inc;
          state_d = ST_SCAN_RD;
        end
      end
      ST_MOVE_RD: begin
        mem_raddr = idx_inc[AW-1:0];
        state_d   = ST_MOVE_WR;
      end
      ST_MOVE_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q[AW-1:0];
        mem_wdata = rd_q;
        idx_d     = idx_inc;
        state_d   = (idx_inc < pcnt_q) ? ST_MOVE_RD : ST_DRAIN;
      end
      ST_LEAF: begin
        if (pcnt_q == '0 && !leaf_q && cnt_q != '0 && cnt_q < MAX_CNT) begin
          cnt_d     = cnt_q + ONE;
          leaf_d    = 1'b1;
          prod      = 1'b1;
          prod_kind = KIND_LEAF_ADD;
          prod_link = '{up: tail_id_q, id: tail_down_q, down: NO_LINK};
          prod_len  = cnt_q + ONE;
        end
        state_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pend_mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= pend_mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      pcnt_q   <= '0;
      leaf_q   <= 1'b0;
      held_v_q <= 1'b0;
      res_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pcnt_q  <= pcnt_d;
      leaf_q  <= leaf_d;
      res_v_q <= 1'b0;
      if (flush) begin
        res_v_q  <= held_v_q;
        held_v_q <= 1'b0;
      end else if (prod) begin
        res_v_q  <= held_v_q;
        held_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    tail_id_q   <= tail_id_d;
    tail_down_q <= tail_down_d;
    rep_q       <= rep_d;
    if (flush || prod) begin
      res_kind_q <= held_kind_q;
      res_link_q <= held_link_q;
      res_len_q  <= held_len_q;
      res_last_q <= flush;
    end
    if (prod) begin
      held_kind_q <= prod_kind;
      held_link_q <= prod_link;
      held_len_q  <= prod_len;
    end
  end

  assign result_valid_o = res_v_q;
  assign kind_o         = res_kind_q;
  assign entry_up_o     = res_link_q.up;
  assign entry_id_o     = res_link_q.id;
  assign entry_down_o   = res_link_q.down;
  assign chain_len_o    = 5'(res_len_q);
  assign last_o         = res_last_q;

  `ASSERT_IMPL(a_chain_bound, clk_i, rst_ni, 1'b1, cnt_q <= MAX_CNT)
  `ASSERT_IMPL(a_pend_bound, clk_i, rst_ni, 1'b1, pcnt_q <= MAX_CNT)
  `ASSERT_IMPL(a_leaf_in_chain, clk_i, rst_ni, leaf_q, cnt_q != '0)
  `ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, accept, busy)

endmodule
